/* hdl/wrpl_pkg.sv */
`default_nettype none

package wrpl_pkg;

    // Accumulator width default
    localparam int unsigned ACC_WIDTH_DEFAULT = 32;

    // Register reset values
    localparam logic [15:0] WINDOW_RESET = 16'd512;
    localparam logic [6:0]  MED_RESET    = 7'd60;
    localparam logic [6:0]  CRIT_RESET   = 7'd95;
    localparam logic [3:0]  PRIO_RESET   = 4'd3;

    // Percent scale and number of quotient bits of the percent division
    localparam logic [6:0]  PCT_FULL  = 7'd100;
    localparam int unsigned PCT_BITS  = 7;

    // Configuration register indexes
    localparam logic [1:0] CFG_WINDOW_PAGES      = 2'd0;
    localparam logic [1:0] CFG_MEDIUM_PERCENT    = 2'd1;
    localparam logic [1:0] CFG_CRITICAL_PERCENT  = 2'd2;
    localparam logic [1:0] CFG_CRITICAL_PRIORITY = 2'd3;

    // Report kinds
    localparam logic ACTION_RECLAIM  = 1'b0;
    localparam logic ACTION_PRIORITY = 1'b1;

    // Pressure levels
    localparam logic [1:0] LEVEL_LOW      = 2'd0;
    localparam logic [1:0] LEVEL_MEDIUM   = 2'd1;
    localparam logic [1:0] LEVEL_CRITICAL = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic load_in;     // latch the accepted report
        logic apply;       // fold the report into the accumulators
        logic capture;     // snapshot totals, clear accumulators
        logic square;      // register r*r
        logic div1_start;  // r*r / s
        logic subtract;    // s - quotient
        logic scale;       // unsuccessful*100 and s+r
        logic div2_start;  // percent division
        logic emit;        // load the result register
    } wrpl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic applies;   // latched report counts
        logic reached;   // scanned total reached the window
        logic zero_pct;  // reclaimed at least scanned
        logic div_busy;
        logic out_free;  // result register can take a value
    } wrpl_status_t;

endpackage

`default_nettype wire

/* hdl/wrpl_div.sv */
`default_nettype none

module wrpl_div
    import wrpl_pkg::*;
#(
    parameter int unsigned ACC_WIDTH = ACC_WIDTH_DEFAULT
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 start,
    input  wire logic [$clog2(ACC_WIDTH + 1)-1:0]     steps,
    input  wire logic [ACC_WIDTH:0]                   rem_init,
    input  wire logic [ACC_WIDTH-1:0]                 low_init,
    input  wire logic [ACC_WIDTH:0]                   divisor,
    output logic                                      busy,
    output logic [ACC_WIDTH-1:0]                      quotient
);

    localparam int unsigned W  = ACC_WIDTH;
    localparam int unsigned SW = $clog2(W + 1);

    logic [SW-1:0] count_reg;
    logic [W:0]    rem_reg;
    logic [W-1:0]  low_reg;
    logic [W:0]    dvs_reg;
    logic [W-1:0]  q_reg;

    logic [W+1:0]  trial;
    logic [W+1:0]  diff;
    logic          fits;

    // One restoring step: bring down the next dividend bit, subtract if it fits
    assign trial = {rem_reg, low_reg[W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = ~diff[W+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (start) begin
            count_reg <= steps;
        end else if (count_reg != '0) begin
            count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= rem_init;
            low_reg <= low_init;
            dvs_reg <= divisor;
            q_reg   <= '0;
        end else if (count_reg != '0) begin
            rem_reg <= fits ? diff[W:0] : trial[W:0];
            low_reg <= {low_reg[W-2:0], 1'b0};
            q_reg   <= {q_reg[W-2:0], fits};
        end
    end

    assign busy     = (count_reg != '0);
    assign quotient = q_reg;

endmodule

`default_nettype wire

/* hdl/wrpl_dp.sv */
`default_nettype none

module wrpl_dp
    import wrpl_pkg::*;
#(
    parameter int unsigned ACC_WIDTH = ACC_WIDTH_DEFAULT
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire wrpl_cmd_t     cmd,
    output wrpl_status_t       status,
    input  wire logic          cfg_write,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [15:0]   cfg_data,
    input  wire logic          s_action,
    input  wire logic          s_alloc_qualifies,
    input  wire logic [15:0]   s_scanned_pages,
    input  wire logic [15:0]   s_reclaimed_pages,
    input  wire logic [3:0]    s_priority_req,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic [1:0]         m_level,
    output logic [6:0]         m_pressure_percent
);

    localparam int unsigned W  = ACC_WIDTH;
    localparam int unsigned NW = W + PCT_BITS;
    localparam int unsigned SW = $clog2(W + 1);

    // Configuration
    logic [15:0] window_reg;
    logic [6:0]  med_reg;
    logic [6:0]  crit_reg;
    logic [3:0]  prio_reg;

    // Latched report
    logic        in_action_reg;
    logic        in_qual_reg;
    logic [15:0] in_sc_reg;
    logic [15:0] in_rc_reg;
    logic [3:0]  in_prio_reg;

    // Accumulators and evaluation registers
    logic [W-1:0]    acc_s_reg;
    logic [W-1:0]    acc_r_reg;
    logic [W-1:0]    s_reg;
    logic [W-1:0]    r_reg;
    logic            zero_reg;
    logic [2*W-1:0]  prod_reg;
    logic [W-1:0]    unsucc_reg;
    logic [NW-1:0]   num_reg;
    logic [W:0]      scale_reg;

    // Result register
    logic            out_valid_reg;
    logic [1:0]      out_level_reg;
    logic [6:0]      out_pct_reg;

    logic            prio_skip;
    logic [15:0]     sc_eff;
    logic [15:0]     rc_eff;
    logic            applies;
    logic [W:0]      sum_s;
    logic [W:0]      sum_r;

    logic            div_start;
    logic [SW-1:0]   div_steps;
    logic [W:0]      div_rem_init;
    logic [W-1:0]    div_low_init;
    logic [W:0]      div_divisor;
    logic            div_busy;
    logic [W-1:0]    div_q;

    logic [6:0]      pct;
    logic [1:0]      level;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= WINDOW_RESET;
            med_reg    <= MED_RESET;
            crit_reg   <= CRIT_RESET;
            prio_reg   <= PRIO_RESET;
        end else if (cfg_write) begin
            unique case (cfg_index)
                CFG_WINDOW_PAGES:      window_reg <= cfg_data;
                CFG_MEDIUM_PERCENT:    med_reg    <= cfg_data[6:0];
                CFG_CRITICAL_PERCENT:  crit_reg   <= cfg_data[6:0];
                CFG_CRITICAL_PRIORITY: prio_reg   <= cfg_data[3:0];
                default:               ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_action_reg <= s_action;
            in_qual_reg   <= s_alloc_qualifies;
            in_sc_reg     <= s_scanned_pages;
            in_rc_reg     <= s_reclaimed_pages;
            in_prio_reg   <= s_priority_req;
        end
    end

    // A priority report at or below the threshold stands for a full window, nothing reclaimed
    assign prio_skip = (in_action_reg == ACTION_PRIORITY) && (in_prio_reg > prio_reg);
    assign sc_eff    = (in_action_reg == ACTION_PRIORITY) ? window_reg : in_sc_reg;
    assign rc_eff    = (in_action_reg == ACTION_PRIORITY) ? 16'd0 : in_rc_reg;
    assign applies   = in_qual_reg && !prio_skip && (sc_eff != 16'd0);

    assign sum_s = {1'b0, acc_s_reg} + {{(W-15){1'b0}}, sc_eff};
    assign sum_r = {1'b0, acc_r_reg} + {{(W-15){1'b0}}, rc_eff};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_s_reg <= '0;
            acc_r_reg <= '0;
        end else if (cmd.capture) begin
            acc_s_reg <= '0;
            acc_r_reg <= '0;
        end else if (cmd.apply && applies) begin
            acc_s_reg <= sum_s[W] ? {W{1'b1}} : sum_s[W-1:0];
            acc_r_reg <= sum_r[W] ? {W{1'b1}} : sum_r[W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            s_reg    <= acc_s_reg;
            r_reg    <= acc_r_reg;
            zero_reg <= (acc_r_reg >= acc_s_reg);
        end
        if (cmd.square) begin
            prod_reg <= r_reg * r_reg;
        end
        if (cmd.subtract) begin
            unsucc_reg <= s_reg - div_q;
        end
        if (cmd.scale) begin
            num_reg   <= unsucc_reg * PCT_FULL;
            scale_reg <= {1'b0, s_reg} + {1'b0, r_reg};
        end
    end

    // Shared divider: r*r/s (quotient below 2^W), then unsuccessful*100/scale (below 2^7)
    always_comb begin
        div_start = cmd.div1_start | cmd.div2_start;
        if (cmd.div2_start) begin
            div_steps    = SW'(PCT_BITS);
            div_rem_init = {1'b0, num_reg[NW-1:PCT_BITS]};
            div_low_init = {num_reg[PCT_BITS-1:0], {(W-PCT_BITS){1'b0}}};
            div_divisor  = scale_reg;
        end else begin
            div_steps    = SW'(W);
            div_rem_init = {1'b0, prod_reg[2*W-1:W]};
            div_low_init = prod_reg[W-1:0];
            div_divisor  = {1'b0, s_reg};
        end
    end

    wrpl_div #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .steps     (div_steps),
        .rem_init  (div_rem_init),
        .low_init  (div_low_init),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .quotient  (div_q)
    );

    assign pct = zero_reg ? 7'd0 : div_q[PCT_BITS-1:0];

    // Critical is tested first
    always_comb begin
        if (pct >= crit_reg) begin
            level = LEVEL_CRITICAL;
        end else if (pct >= med_reg) begin
            level = LEVEL_MEDIUM;
        end else begin
            level = LEVEL_LOW;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_level_reg <= level;
            out_pct_reg   <= pct;
        end
    end

    assign status.applies  = applies;
    assign status.reached  = (acc_s_reg >= {{(W-16){1'b0}}, window_reg});
    assign status.zero_pct = zero_reg;
    assign status.div_busy = div_busy;
    assign status.out_free = !out_valid_reg || m_ready;

    assign m_valid            = out_valid_reg;
    assign m_level            = out_level_reg;
    assign m_pressure_percent = out_pct_reg;

endmodule

`default_nettype wire

/* hdl/wrpl_ctrl.sv */
`default_nettype none

module wrpl_ctrl
    import wrpl_pkg::*;
(
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    output wrpl_cmd_t          cmd,
    input  wire wrpl_status_t  status
);

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_APPLY     = 4'd1;
    localparam logic [3:0] ST_CHECK     = 4'd2;
    localparam logic [3:0] ST_SQUARE    = 4'd3;
    localparam logic [3:0] ST_DIV1_GO   = 4'd4;
    localparam logic [3:0] ST_DIV1_WAIT = 4'd5;
    localparam logic [3:0] ST_SUBTRACT  = 4'd6;
    localparam logic [3:0] ST_SCALE     = 4'd7;
    localparam logic [3:0] ST_DIV2_GO   = 4'd8;
    localparam logic [3:0] ST_DIV2_WAIT = 4'd9;
    localparam logic [3:0] ST_EMIT      = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_APPLY;
                end
            end
            ST_APPLY: begin
                cmd.apply  = 1'b1;
                state_next = status.applies ? ST_CHECK : ST_IDLE;
            end
            ST_CHECK: begin
                if (status.reached) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_SQUARE;
                end else begin
                    state_next  = ST_IDLE;
                end
            end
            ST_SQUARE: begin
                cmd.square = 1'b1;
                state_next = status.zero_pct ? ST_EMIT : ST_DIV1_GO;
            end
            ST_DIV1_GO: begin
                cmd.div1_start = 1'b1;
                state_next     = ST_DIV1_WAIT;
            end
            ST_DIV1_WAIT: begin
                if (!status.div_busy) begin
                    state_next = ST_SUBTRACT;
                end
            end
            ST_SUBTRACT: begin
                cmd.subtract = 1'b1;
                state_next   = ST_SCALE;
            end
            ST_SCALE: begin
                cmd.scale  = 1'b1;
                state_next = ST_DIV2_GO;
            end
            ST_DIV2_GO: begin
                cmd.div2_start = 1'b1;
                state_next     = ST_DIV2_WAIT;
            end
            ST_DIV2_WAIT: begin
                if (!status.div_busy) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hdl/windowed_reclaim_pressure_level.sv */
// Channel  | Ports                                              | Direction
// ---------+----------------------------------------------------+----------
// report   | s_valid/s_ready, s_action, s_alloc_qualifies,      | in
//          | s_scanned_pages, s_reclaimed_pages, s_priority_req |
// result   | m_valid/m_ready, m_level, m_pressure_percent       | out
// config   | cfg_valid/cfg_ready, cfg_index, cfg_data           | in
//
// Between a transfer and the next s_ready, an ignored report, one that stays below
// the window and one with reclaimed >= scanned each take a shorter path than a full
// evaluation, whose length is set by two passes through one bit-per-cycle restoring
// divider (ACC_WIDTH steps for r*r/s, 7 for the percent).
// A due result holds the block only while the previous one still waits on m_ready.
// Reset is synchronous, active low: register defaults, accumulators cleared.
`default_nettype none

module windowed_reclaim_pressure_level
    import wrpl_pkg::*;
#(
    parameter int unsigned ACC_WIDTH = ACC_WIDTH_DEFAULT
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,

    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [15:0]   cfg_data,

    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic          s_action,
    input  wire logic          s_alloc_qualifies,
    input  wire logic [15:0]   s_scanned_pages,
    input  wire logic [15:0]   s_reclaimed_pages,
    input  wire logic [3:0]    s_priority_req,

    output logic               m_valid,
    input  wire logic          m_ready,
    output logic [1:0]         m_level,
    output logic [6:0]         m_pressure_percent
);

    wrpl_cmd_t    cmd;
    wrpl_status_t status;

    // Register writes are always taken; software writes only while idle
    assign cfg_ready = 1'b1;

    // Sequencer: one report at a time, steps the datapath through the evaluation
    wrpl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .status  (status)
    );

    // Accumulators, multiplier, shared divider, grading and result register
    wrpl_dp #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .status             (status),
        .cfg_write          (cfg_valid && cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_action           (s_action),
        .s_alloc_qualifies  (s_alloc_qualifies),
        .s_scanned_pages    (s_scanned_pages),
        .s_reclaimed_pages  (s_reclaimed_pages),
        .s_priority_req     (s_priority_req),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_level            (m_level),
        .m_pressure_percent (m_pressure_percent)
    );

endmodule

`default_nettype wire

/* hdl/wrpl_checker.sv */
`default_nettype none

module wrpl_checker
    import wrpl_pkg::*;
(
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [1:0] m_level,
    input wire logic [6:0] m_pressure_percent
);

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_level) && $stable(m_pressure_percent))
        else $error("result changed while stalled");

    // Percent never exceeds full scale
    a_pct_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_pressure_percent <= PCT_FULL)
        else $error("pressure percent above 100");

    // Level is one of the three grades
    a_level_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_level == LEVEL_LOW) || (m_level == LEVEL_MEDIUM)
                    || (m_level == LEVEL_CRITICAL))
        else $error("illegal pressure level");

    // One report at a time: ready drops right after a transfer
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("report taken while one is in progress");

endmodule

bind windowed_reclaim_pressure_level wrpl_checker u_wrpl_checker (.*);

`default_nettype wire

/* dv/windowed_reclaim_pressure_level_test.sv */
`default_nettype none

module windowed_reclaim_pressure_level_test;
    import wrpl_pkg::*;

    localparam int unsigned HALF_PERIOD    = 10;
    localparam int unsigned RESET_CYCLES   = 9;
    localparam int unsigned ACC_W          = ACC_WIDTH_DEFAULT;
    // Drain time covers the longest evaluation, with margin for the result register.
    localparam int unsigned DRAIN_CYCLES   = ACC_W + 18 + 16;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned PHASE_REPORTS  = 60;
    localparam int unsigned PHASES         = 10;
    localparam int unsigned FIXED_PHASES   = 6;

    typedef struct packed {
        logic [1:0] level;
        logic [6:0] percent;
    } pressure_result_t;

    // Tracks the register file and the two window totals, and keeps the
    // evaluations still owed by the block in order.
    class pressure_scoreboard;
        logic [15:0]       window_pages;
        logic [6:0]        medium_pct;
        logic [6:0]        critical_pct;
        logic [3:0]        critical_prio;
        longint unsigned   scanned_total;
        longint unsigned   reclaimed_total;
        pressure_result_t  due_q[$];
        int unsigned       checked;
        int unsigned       failures;

        function new();
            window_pages    = WINDOW_RESET;
            medium_pct      = MED_RESET;
            critical_pct    = CRIT_RESET;
            critical_prio   = PRIO_RESET;
            scanned_total   = 0;
            reclaimed_total = 0;
            checked         = 0;
            failures        = 0;
        endfunction

        function void write_register(logic [1:0] index, logic [15:0] data);
            case (index)
                CFG_WINDOW_PAGES:      window_pages  = data;
                CFG_MEDIUM_PERCENT:    medium_pct    = data[6:0];
                CFG_CRITICAL_PERCENT:  critical_pct  = data[6:0];
                CFG_CRITICAL_PRIORITY: critical_prio = data[3:0];
                default: ;
            endcase
        endfunction

        // Fold one accepted report into the totals; returns 1 if it counted.
        function bit note_report(logic action, logic qualifies, logic [15:0] scanned,
                                 logic [15:0] reclaimed, logic [3:0] prio_lvl);
            longint unsigned  acc_max;
            longint unsigned  add_s;
            longint unsigned  add_r;
            longint unsigned  s;
            longint unsigned  r;
            longint unsigned  pct;
            pressure_result_t res;
            acc_max = (64'd1 << ACC_W) - 1;
            add_s   = 64'(scanned);
            add_r   = 64'(reclaimed);
            if (action == ACTION_PRIORITY) begin
                if (prio_lvl > critical_prio)
                    return 0;
                add_s = 64'(window_pages);
                add_r = 0;
            end
            if (!qualifies || add_s == 0)
                return 0;
            scanned_total   = (scanned_total + add_s > acc_max) ? acc_max
                                                                : scanned_total + add_s;
            reclaimed_total = (reclaimed_total + add_r > acc_max) ? acc_max
                                                                  : reclaimed_total + add_r;
            if (scanned_total < 64'(window_pages))
                return 1;
            s = scanned_total;
            r = reclaimed_total;
            scanned_total   = 0;
            reclaimed_total = 0;
            if (r >= s)
                pct = 0;
            else
                pct = ((s - (r * r) / s) * 100) / (s + r);
            res.percent = pct[6:0];
            if (res.percent >= critical_pct)
                res.level = LEVEL_CRITICAL;
            else if (res.percent >= medium_pct)
                res.level = LEVEL_MEDIUM;
            else
                res.level = LEVEL_LOW;
            due_q.push_back(res);
            return 1;
        endfunction

        function void check_result(logic [1:0] level, logic [6:0] percent);
            pressure_result_t want;
            checked++;
            if (due_q.size() == 0) begin
                $error("result with no evaluation pending: level %0d percent %0d",
                       level, percent);
                failures++;
                return;
            end
            want = due_q.pop_front();
            if (level !== want.level) begin
                $error("level: expected %0d, got %0d", want.level, level);
                failures++;
            end
            if (percent !== want.percent) begin
                $error("pressure_percent: expected %0d, got %0d", want.percent, percent);
                failures++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic        s_action;
    logic        s_alloc_qualifies;
    logic [15:0] s_scanned_pages;
    logic [15:0] s_reclaimed_pages;
    logic [3:0]  s_priority_req;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_level;
    logic [6:0]  m_pressure_percent;

    pressure_scoreboard sb = new();

    // When set, both sides run back to back with no idle cycles.
    bit          steady;
    int unsigned reports_sent;
    int unsigned reports_counted;
    int unsigned settings_applied;
    int unsigned idle_cycles;

    windowed_reclaim_pressure_level dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_action           (s_action),
        .s_alloc_qualifies  (s_alloc_qualifies),
        .s_scanned_pages    (s_scanned_pages),
        .s_reclaimed_pages  (s_reclaimed_pages),
        .s_priority_req     (s_priority_req),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_level            (m_level),
        .m_pressure_percent (m_pressure_percent)
    );

    initial begin
        aclk = 1'b0;
        forever #HALF_PERIOD aclk = ~aclk;
    end

    // Watchdog: end the run once no transfer happens on any channel for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Result side. Draw a stall per result; on a nonzero stall, hold m_ready low
    // until the block shows a result, then wait out the stall before taking it.
    initial begin
        int unsigned stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 3);
            if (stall != 0) begin
                m_ready = 1'b0;
                do @(posedge aclk); while (!m_valid);
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
            sb.check_result(m_level, m_pressure_percent);
            @(negedge aclk);
        end
    end

    // Present one report, hold it until the transfer, and note it.
    // Called and returns at a falling edge; valid stays high if the next
    // report follows with no gap.
    task automatic send_report(logic action, logic qualifies, logic [15:0] scanned,
                               logic [15:0] reclaimed, logic [3:0] prio_lvl);
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_action          = action;
        s_alloc_qualifies = qualifies;
        s_scanned_pages   = scanned;
        s_reclaimed_pages = reclaimed;
        s_priority_req    = prio_lvl;
        s_valid           = 1'b1;
        do @(posedge aclk); while (!s_ready);
        reports_sent++;
        if (sb.note_report(action, qualifies, scanned, reclaimed, prio_lvl))
            reports_counted++;
        @(negedge aclk);
    endtask

    // Drop valid, wait for every owed result, then let a report that causes
    // no result finish before anything else happens.
    task automatic settle();
        s_valid = 1'b0;
        while (sb.due_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Write one register; unused upper data bits carry noise. Leaves cfg_valid high.
    task automatic write_register(logic [1:0] index, logic [15:0] value, int unsigned width);
        logic [15:0] noise;
        noise     = 16'($urandom);
        noise     = noise << width;
        cfg_index = index;
        cfg_data  = value | noise;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_register(cfg_index, cfg_data);
        @(negedge aclk);
    endtask

    task automatic apply_setting(logic [15:0] window, logic [6:0] med_pct,
                                 logic [6:0] crit_pct, logic [3:0] crit_prio);
        settle();
        write_register(CFG_WINDOW_PAGES, window, 16);
        write_register(CFG_MEDIUM_PERCENT, {9'd0, med_pct}, 7);
        write_register(CFG_CRITICAL_PERCENT, {9'd0, crit_pct}, 7);
        write_register(CFG_CRITICAL_PRIORITY, {12'd0, crit_prio}, 4);
        cfg_valid = 1'b0;
        settings_applied++;
    endtask

    // Random reports until enough of them count. Most are qualifying reclaim
    // reports sized against the window so evaluations come often; the rest are
    // priority reports, zero scans, full-range values and non-qualifying noise.
    task automatic run_random_reports(int unsigned target);
        int unsigned start;
        int unsigned pick;
        logic        action;
        logic        qualifies;
        logic [15:0] scanned;
        logic [15:0] reclaimed;
        logic [3:0]  prio_lvl;
        start = reports_counted;
        while (reports_counted - start < target) begin
            if (reports_sent % 16 == 0)
                steady = ($urandom_range(0, 2) == 0);
            qualifies = ($urandom_range(0, 9) != 0);
            scanned   = 16'($urandom);
            reclaimed = 16'($urandom);
            if ($urandom_range(0, 1))
                prio_lvl = 4'($urandom_range(0, sb.critical_prio));
            else
                prio_lvl = 4'($urandom_range(0, 15));
            if ($urandom_range(0, 99) < 15) begin
                action = ACTION_PRIORITY;
            end else begin
                action = ACTION_RECLAIM;
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    scanned = 16'd0;
                else if (pick > 2)
                    scanned = 16'($urandom_range(1, sb.window_pages / 3 + 1));
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    reclaimed = 16'd0;
                else if (pick == 2)
                    reclaimed = scanned;
                else if (pick > 2)
                    reclaimed = 16'($urandom_range(0, scanned));
            end
            send_report(action, qualifies, scanned, reclaimed, prio_lvl);
        end
    endtask

    initial begin
        int unsigned win_set[FIXED_PHASES]  = '{1, 0, 65535, 300, 1000, 512};
        int unsigned med_set[FIXED_PHASES]  = '{0, 60, 127, 100, 90, 60};
        int unsigned crit_set[FIXED_PHASES] = '{127, 95, 127, 0, 40, 95};
        int unsigned prio_set[FIXED_PHASES] = '{0, 15, 12, 5, 3, 3};
        int unsigned phase;
        logic [15:0] window;

        aresetn           = 1'b0;
        cfg_valid         = 1'b0;
        cfg_index         = CFG_WINDOW_PAGES;
        cfg_data          = '0;
        s_valid           = 1'b0;
        s_action          = ACTION_RECLAIM;
        s_alloc_qualifies = 1'b0;
        s_scanned_pages   = '0;
        s_reclaimed_pages = '0;
        s_priority_req    = '0;
        steady            = 1'b0;
        reports_sent      = 0;
        reports_counted   = 0;
        settings_applied  = 0;
        idle_cycles       = 0;

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn = 1'b1;

        // Directed part on reset register values: window 512, medium 60,
        // critical 95, critical priority 3.
        send_report(ACTION_RECLAIM,  1'b1, 16'd512,   16'd0,     4'd0);  // full window, 100
        send_report(ACTION_RECLAIM,  1'b1, 16'd0,     16'd65535, 4'd15); // zero scan: drop
        send_report(ACTION_RECLAIM,  1'b0, 16'd65535, 16'd0,     4'd0);  // not counted kind
        send_report(ACTION_PRIORITY, 1'b1, 16'd0,     16'd0,     4'd3);  // at threshold
        send_report(ACTION_PRIORITY, 1'b1, 16'd65535, 16'd65535, 4'd4);  // above threshold
        send_report(ACTION_PRIORITY, 1'b0, 16'd100,   16'd0,     4'd0);  // not counted kind
        send_report(ACTION_PRIORITY, 1'b1, 16'd0,     16'd0,     4'd15); // top priority
        send_report(ACTION_PRIORITY, 1'b1, 16'd0,     16'd0,     4'd0);
        send_report(ACTION_RECLAIM,  1'b1, 16'd65535, 16'd65535, 4'd0);  // reclaimed >= scanned
        send_report(ACTION_RECLAIM,  1'b1, 16'd300,   16'd100,   4'd0);  // window built in two
        send_report(ACTION_RECLAIM,  1'b1, 16'd300,   16'd200,   4'd0);
        send_report(ACTION_RECLAIM,  1'b1, 16'd400,   16'd0,     4'd0);  // partial, then inject
        send_report(ACTION_PRIORITY, 1'b1, 16'd0,     16'd0,     4'd2);
        send_report(ACTION_RECLAIM,  1'b1, 16'd511,   16'd0,     4'd0);  // one short of window
        send_report(ACTION_RECLAIM,  1'b1, 16'd1,     16'd65535, 4'd0);
        send_report(ACTION_RECLAIM,  1'b1, 16'd1000,  16'd700,   4'd0);  // low
        send_report(ACTION_RECLAIM,  1'b1, 16'd1000,  16'd200,   4'd0);  // medium
        send_report(ACTION_RECLAIM,  1'b1, 16'd65535, 16'd1,     4'd0);  // critical
        send_report(ACTION_RECLAIM,  1'b1, 16'd1000,  16'd999,   4'd0);  // rounds to 0
        send_report(ACTION_RECLAIM,  1'b1, 16'd1000,  16'd50,    4'd0);  // exactly critical
        send_report(ACTION_RECLAIM,  1'b1, 16'd1000,  16'd400,   4'd0);  // exactly medium

        // Random part over several register settings: the fixed ones cover
        // window of one and zero, the largest window, thresholds at both ends,
        // medium above critical and every priority threshold extreme.
        for (phase = 0; phase < PHASES; phase++) begin
            if (phase < FIXED_PHASES) begin
                apply_setting(16'(win_set[phase]), 7'(med_set[phase]), 7'(crit_set[phase]),
                              4'(prio_set[phase]));
            end else begin
                window = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                     : 16'($urandom_range(1, 3000));
                apply_setting(window, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                              4'($urandom_range(0, 15)));
            end
            run_random_reports(PHASE_REPORTS);
        end

        settle();
        if (sb.due_q.size() != 0) begin
            $error("%0d evaluations never came out", sb.due_q.size());
            sb.failures++;
        end

        $display("Run covered %0d reports (%0d counted) over %0d register settings,",
                 reports_sent, reports_counted, settings_applied);
        $display("with %0d pressure results checked and %0d mismatches.",
                 sb.checked, sb.failures);
        if (sb.failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
hdl/wrpl_pkg.sv
hdl/wrpl_div.sv
hdl/wrpl_dp.sv
hdl/wrpl_ctrl.sv
hdl/windowed_reclaim_pressure_level.sv
hdl/wrpl_checker.sv
dv/windowed_reclaim_pressure_level_test.sv
